@@ hw/rtl/dtbe_pkg.sv @@
`timescale 1ns / 1ps
package dtbe_pkg;

  // token kinds
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_LIT    = 2'd1;
  localparam logic [1:0] OP_MATCH  = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  // configuration register indexes
  localparam logic [0:0] CFG_LIT_MODE  = 1'b0;
  localparam logic [0:0] CFG_DICT_BITS = 1'b1;

  localparam logic [2:0] DICT_MIN   = 3'd4;
  localparam logic [2:0] DICT_MAX   = 3'd6;
  localparam logic [2:0] DICT_RESET = 3'd6;
  localparam logic [2:0] SHORT_LOW  = 3'd2;

  localparam logic [9:0] LEN_LO = 10'd2;
  localparam logic [9:0] LEN_HI = 10'd518;

  typedef logic [7:0] byte_tbl_t [256];

  // literal value at each rank of the fixed ASCII code
  localparam byte_tbl_t ASCII_RANK = '{
    8'h20, 8'h45, 8'h61, 8'h65, 8'h69, 8'h6c, 8'h6e, 8'h6f, 8'h72, 8'h73, 8'h74, 8'h75,
    8'h2d, 8'h31, 8'h41, 8'h43, 8'h44, 8'h49, 8'h4c, 8'h4e, 8'h4f, 8'h52, 8'h53, 8'h54,
    8'h62, 8'h63, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6d, 8'h70,
    8'h0a, 8'h0d, 8'h28, 8'h29, 8'h2c, 8'h2e, 8'h30, 8'h32, 8'h33, 8'h34, 8'h35, 8'h37,
    8'h38, 8'h3d, 8'h42, 8'h46, 8'h4d, 8'h50, 8'h55, 8'h6b, 8'h77,
    8'h09, 8'h22, 8'h27, 8'h2a, 8'h2f, 8'h36, 8'h39, 8'h3a, 8'h47, 8'h48, 8'h57,
    8'h5b, 8'h5f, 8'h76, 8'h78, 8'h79,
    8'h2b, 8'h3e, 8'h4b, 8'h56, 8'h58, 8'h59, 8'h5d,
    8'h21, 8'h24, 8'h26, 8'h71, 8'h7a,
    8'h00, 8'h3c, 8'h3f, 8'h4a, 8'h51, 8'h5a, 8'h5c, 8'h6a, 8'h7b, 8'h7c,
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h0b, 8'h0c, 8'h0e, 8'h0f,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1b, 8'h1c,
    8'h1d, 8'h1e, 8'h1f, 8'h23, 8'h25, 8'h3b, 8'h40, 8'h5e, 8'h60, 8'h7d, 8'h7e, 8'h7f,
    8'hb0, 8'hb1, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hbb,
    8'hbc, 8'hbd, 8'hbe, 8'hbf, 8'hc0, 8'hc1, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
    8'hc8, 8'hc9, 8'hca, 8'hcb, 8'hcc, 8'hcd, 8'hce, 8'hcf, 8'hd0, 8'hd1, 8'hd2, 8'hd3,
    8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde, 8'hdf,
    8'he1, 8'he5, 8'he9, 8'hee, 8'hf2, 8'hf3, 8'hf4,
    8'h1a, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
    8'h97, 8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'h9f, 8'ha0, 8'ha1, 8'ha2,
    8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hab, 8'hac, 8'had, 8'hae,
    8'haf, 8'he0, 8'he2, 8'he3, 8'he4, 8'he6, 8'he7, 8'he8, 8'hea, 8'heb, 8'hec, 8'hed,
    8'hef, 8'hf0, 8'hf1, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd,
    8'hfe, 8'hff
  };

  // inverse table, built at elaboration; a repeated value keeps its highest rank
  function automatic byte_tbl_t build_lit_rank();
    byte_tbl_t r;
    for (int i = 0; i < 256; i++) begin
      r[i] = 8'hFF;
    end
    for (int i = 0; i < 256; i++) begin
      r[ASCII_RANK[i]] = 8'(i);
    end
    return r;
  endfunction

  localparam byte_tbl_t LIT_RANK = build_lit_rank();

  // ASCII literal groups
  localparam logic [7:0] LIT_MIN  [10] = '{8'd182, 8'd91, 8'd81, 8'd76, 8'd69,
                                          8'd53, 8'd32, 8'd12, 8'd1, 8'd0};
  localparam logic [3:0] LIT_BITS [10] = '{4'd13, 4'd12, 4'd11, 4'd10, 4'd9,
                                          4'd8, 4'd7, 4'd6, 4'd5, 4'd4};
  localparam logic [6:0] LIT_CODE [10] = '{7'h49, 7'h7F, 7'h49, 7'h29, 7'h1b,
                                          7'h1d, 7'h23, 7'h25, 7'h1d, 7'h0F};

  // offset high part groups
  localparam logic [5:0] OFF_MIN  [6] = '{6'h30, 6'h16, 6'h07, 6'h03, 6'h01, 6'h00};
  localparam logic [3:0] OFF_BITS [6] = '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd2};
  localparam logic [7:0] OFF_CODE [6] = '{8'h0F, 8'h21, 8'h1F, 8'h13, 8'h0B, 8'h03};

  // length groups
  localparam logic [8:0] LEN_MIN  [16] = '{9'd264, 9'd136, 9'd72, 9'd40, 9'd24, 9'd16,
                                          9'd12, 9'd10, 9'd9, 9'd8, 9'd7, 9'd6,
                                          9'd5, 9'd4, 9'd3, 9'd2};
  localparam logic [2:0] LEN_BITS [16] = '{3'd7, 3'd7, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5, 3'd5,
                                          3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd3};
  localparam logic [2:0] LEN_CODE [16] = '{3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4,
                                          3'd5, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd3, 3'd5};
  localparam logic [3:0] LEN_XTRA [16] = '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1,
                                          4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};

  // one token after classification: up to four LSB-first bit fields
  typedef struct packed {
    logic        start;
    logic        finish;
    logic [13:0] seg0;
    logic [3:0]  w0;
    logic [7:0]  seg1;
    logic [3:0]  w1;
    logic [7:0]  seg2;
    logic [3:0]  w2;
    logic [5:0]  seg3;
    logic [2:0]  w3;
  } seg_t;

  // token bits packed into one vector
  typedef struct packed {
    logic        start;
    logic        finish;
    logic [29:0] vec;
    logic [4:0]  tot;
  } vec_t;

  // queue entry: up to four completed bytes
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
  } entry_t;

endpackage

@@ hw/rtl/dtbe_if.sv @@
`timescale 1ns / 1ps
interface dtbe_tok_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] literal;
  logic [9:0] match_length;
  logic [11:0] offset;

  modport source (output valid, output op, output literal, output match_length,
                  output offset, input ready);
  modport sink (input valid, input op, input literal, input match_length,
                input offset, output ready);
endinterface

interface dtbe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

@@ hw/rtl/dtbe_front.sv @@
`timescale 1ns / 1ps
module dtbe_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             lit_mode_i,
  input  logic [2:0]       dict_bits_i,
  dtbe_tok_if.sink         tok,
  output logic             push_valid_o,
  output dtbe_pkg::entry_t push_entry_o,
  input  logic             push_ready_i
);
  import dtbe_pkg::*;

  logic        a_valid_q, b_valid_q;
  seg_t        a_d, a_q;
  vec_t        b_d, b_q;
  logic        a_free, b_take, b_free;

  logic [6:0]  pbits_q, pbits_d;
  logic [2:0]  pcnt_q, pcnt_d;

  // classification signals
  logic [2:0]  eff_dict;
  logic [7:0]  rank, lit_diff;
  logic [3:0]  lit_g, lit_w;
  logic [12:0] lit_val, lit_rev;
  logic [12:0] lit_msb;
  logic [9:0]  len, len_x;
  logic [3:0]  len_g;
  logic [6:0]  len_val, len_rev, len_msb;
  logic [2:0]  low_n;
  logic [11:0] off_sh;
  logic [5:0]  hi, low_mask, low_val;
  logic [2:0]  off_g;
  logic [7:0]  off_val, off_rev, off_msb;

  // packing signals
  logic [4:0]  p1, p2, p3;
  logic [36:0] acc, rest;
  logic [5:0]  nbits;
  logic [2:0]  nbytes;

  assign eff_dict = (dict_bits_i < DICT_MIN) ? DICT_MIN :
                    (dict_bits_i > DICT_MAX) ? DICT_MAX : dict_bits_i;

  // stage A: table lookups and code selection
  always_comb begin
    rank = LIT_RANK[tok.literal];
    lit_g = 4'd9;
    for (int g = 8; g >= 0; g--) begin
      if (rank >= LIT_MIN[g]) lit_g = 4'(g);
    end
    lit_diff = rank - LIT_MIN[lit_g];
    lit_val  = 13'(LIT_CODE[lit_g]) - 13'(lit_diff);
    lit_w    = LIT_BITS[lit_g];
    for (int j = 0; j < 13; j++) begin
      lit_rev[j] = lit_val[12-j];
    end
    lit_msb = lit_rev >> (4'd13 - lit_w);

    if (tok.match_length < LEN_LO) begin
      len = LEN_LO;
    end else if (tok.match_length > LEN_HI) begin
      len = LEN_HI;
    end else begin
      len = tok.match_length;
    end
    len_g = 4'd15;
    for (int g = 14; g >= 0; g--) begin
      if (len >= 10'(LEN_MIN[g])) len_g = 4'(g);
    end
    len_x   = len - 10'(LEN_MIN[len_g]);
    len_val = 7'(LEN_CODE[len_g]);
    for (int j = 0; j < 7; j++) begin
      len_rev[j] = len_val[6-j];
    end
    len_msb = len_rev >> (3'd7 - LEN_BITS[len_g]);

    // a length-two match always carries two low offset bits
    low_n  = (len == LEN_LO) ? SHORT_LOW : eff_dict;
    off_sh = tok.offset >> low_n;
    hi     = off_sh[5:0];
    off_g  = 3'd5;
    for (int g = 4; g >= 0; g--) begin
      if (hi >= OFF_MIN[g]) off_g = 3'(g);
    end
    off_val = OFF_CODE[off_g] - 8'(hi - OFF_MIN[off_g]);
    for (int j = 0; j < 8; j++) begin
      off_rev[j] = off_val[7-j];
    end
    off_msb  = off_rev >> (4'd8 - OFF_BITS[off_g]);
    low_mask = 6'((7'd1 << low_n) - 7'd1);
    low_val  = tok.offset[5:0] & low_mask;

    a_d = '0;
    case (tok.op)
      OP_START: begin
        a_d.start = 1'b1;
        a_d.seg0  = {13'd0, lit_mode_i};
        a_d.w0    = 4'd8;
        a_d.seg1  = {5'd0, eff_dict};
        a_d.w1    = 4'd8;
      end
      OP_LIT: begin
        if (lit_mode_i) begin
          a_d.seg0 = {lit_msb, 1'b0};
          a_d.w0   = lit_w + 4'd1;
        end else begin
          a_d.seg0 = {5'd0, tok.literal, 1'b0};
          a_d.w0   = 4'd9;
        end
      end
      OP_MATCH: begin
        a_d.seg0 = {6'd0, len_msb, 1'b1};
        a_d.w0   = 4'(LEN_BITS[len_g]) + 4'd1;
        a_d.seg1 = len_x[7:0];
        a_d.w1   = LEN_XTRA[len_g];
        a_d.seg2 = off_msb;
        a_d.w2   = OFF_BITS[off_g];
        a_d.seg3 = low_val;
        a_d.w3   = low_n;
      end
      OP_FINISH: begin
        // end marker: flag, seven zero code bits, 0xFF extra bits
        a_d.finish = 1'b1;
        a_d.seg0   = 14'd1;
        a_d.w0     = 4'd8;
        a_d.seg1   = 8'hFF;
        a_d.w1     = 4'd8;
      end
      default: a_d = '0;
    endcase
  end

  // stage B: join the fields into one vector
  always_comb begin
    p1 = 5'(a_q.w0);
    p2 = p1 + 5'(a_q.w1);
    p3 = p2 + 5'(a_q.w2);
    b_d.start  = a_q.start;
    b_d.finish = a_q.finish;
    b_d.vec    = 30'(a_q.seg0) | (30'(a_q.seg1) << p1) | (30'(a_q.seg2) << p2)
               | (30'(a_q.seg3) << p3);
    b_d.tot    = p3 + 5'(a_q.w3);
  end

  // stage C: merge with pending bits, cut whole bytes; start resets them
  always_comb begin
    acc   = ({7'd0, b_q.vec} << pcnt_q) | 37'(pbits_q);
    nbits = 6'(pcnt_q) + 6'(b_q.tot);
    if (b_q.finish) nbits = (nbits + 6'd7) & 6'b111000;
    nbytes = nbits[5:3];
    rest   = acc >> {nbytes, 3'b000};
    if (b_q.start) begin
      push_entry_o.data = {16'd0, b_q.vec[15:0]};
      push_entry_o.cnt  = 3'd2;
      pbits_d           = '0;
      pcnt_d            = '0;
    end else begin
      push_entry_o.data = acc[31:0];
      push_entry_o.cnt  = nbytes;
      pbits_d           = rest[6:0];
      pcnt_d            = nbits[2:0];
    end
  end

  assign push_valid_o = b_valid_q && (push_entry_o.cnt != 3'd0);
  assign b_take       = b_valid_q && ((push_entry_o.cnt == 3'd0) || push_ready_i);
  assign b_free       = !b_valid_q || b_take;
  assign a_free       = !a_valid_q || b_free;
  assign tok.ready    = a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      pbits_q   <= '0;
      pcnt_q    <= '0;
    end else begin
      if (a_free) a_valid_q <= tok.valid;
      if (b_free) b_valid_q <= a_valid_q;
      if (b_take) begin
        pbits_q <= pbits_d;
        pcnt_q  <= pcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && tok.valid) a_q <= a_d;
    if (b_free && a_valid_q) b_q <= b_d;
  end

endmodule

@@ hw/rtl/dtbe_queue.sv @@
`timescale 1ns / 1ps
module dtbe_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  dtbe_pkg::entry_t push_entry_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output dtbe_pkg::entry_t pop_entry_o,
  input  logic             pop_ready_i
);
  import dtbe_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

@@ hw/rtl/dtbe_back.sv @@
`timescale 1ns / 1ps
module dtbe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  dtbe_pkg::entry_t pop_entry_i,
  output logic             pop_ready_o,
  dtbe_byte_if.source      bytes
);
  import dtbe_pkg::*;

  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        ol_q, ol_d;
  logic [23:0] buf_q, buf_d;
  logic [1:0]  bcnt_q, bcnt_d;
  logic        out_free;

  assign out_free    = !ov_q || bytes.ready;
  assign pop_ready_o = out_free && (bcnt_q == 2'd0);

  // drain the held entry first, then take the next one from the queue
  always_comb begin
    ov_d   = ov_q;
    ob_d   = ob_q;
    ol_d   = ol_q;
    buf_d  = buf_q;
    bcnt_d = bcnt_q;
    if (out_free) begin
      if (bcnt_q != 2'd0) begin
        ov_d   = 1'b1;
        ob_d   = buf_q[7:0];
        ol_d   = (bcnt_q == 2'd1);
        buf_d  = buf_q >> 8;
        bcnt_d = bcnt_q - 2'd1;
      end else if (pop_valid_i) begin
        ov_d   = 1'b1;
        ob_d   = pop_entry_i.data[7:0];
        ol_d   = (pop_entry_i.cnt == 3'd1);
        buf_d  = pop_entry_i.data[31:8];
        bcnt_d = 2'(pop_entry_i.cnt - 3'd1);
      end else begin
        ov_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      bcnt_q <= '0;
    end else begin
      ov_q   <= ov_d;
      bcnt_q <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q  <= ob_d;
    ol_q  <= ol_d;
    buf_q <= buf_d;
  end

  assign bytes.valid    = ov_q;
  assign bytes.out_byte = ob_q;
  assign bytes.last     = ol_q;

endmodule

@@ hw/rtl/dcl_token_bitstream_encoder_core.sv @@
`timescale 1ns / 1ps
// Token to bit stream encoder for the DCL implode format.
// tok: one compressor token per transaction (start, literal, match, finish).
// bytes: the packed LSB-first stream, one byte per transaction; last marks
// the final byte a token produces. Tokens that complete no byte give none.
// cfg: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 literal mode,
// 1 dictionary bits); write only while no token is in flight.
// Throughput: the front takes one token per cycle, unless the queue is full,
// through a three-step classify/join/pack pipeline; the byte output register
// drains one byte per cycle while the receiver is ready. A token produces
// at most four bytes.
// A two-entry queue between front and byte drain lets the front keep
// accepting while the receiver stalls; when it fills, tok.ready drops.
// Reset empties the pipeline, clears the pending bits and sets literal mode
// to raw and dictionary bits to 6.
module dcl_token_bitstream_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [2:0] cfg_data_i,
  dtbe_tok_if.sink   tok,
  dtbe_byte_if.source bytes
);
  import dtbe_pkg::*;

  logic       lit_mode_q;
  logic [2:0] dict_bits_q;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_entry, pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_mode_q  <= 1'b0;
      dict_bits_q <= DICT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LIT_MODE:  lit_mode_q  <= cfg_data_i[0];
        CFG_DICT_BITS: dict_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dtbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lit_mode_i   (lit_mode_q),
    .dict_bits_i  (dict_bits_q),
    .tok          (tok),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  dtbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  dtbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .bytes       (bytes)
  );

endmodule

@@ bench/dcl_token_bitstream_encoder_core_test.sv @@
`timescale 1ns / 1ps
module dcl_token_bitstream_encoder_core_test;
  import dtbe_pkg::*;

  // byte value at each rank of the fixed ASCII literal code
  localparam logic [7:0] RANK_VALUE [256] = '{
    8'h20, 8'h45, 8'h61, 8'h65, 8'h69, 8'h6c, 8'h6e, 8'h6f, 8'h72, 8'h73, 8'h74, 8'h75,
    8'h2d, 8'h31, 8'h41, 8'h43, 8'h44, 8'h49, 8'h4c, 8'h4e, 8'h4f, 8'h52, 8'h53, 8'h54,
    8'h62, 8'h63, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6d, 8'h70,
    8'h0a, 8'h0d, 8'h28, 8'h29, 8'h2c, 8'h2e, 8'h30, 8'h32, 8'h33, 8'h34, 8'h35, 8'h37,
    8'h38, 8'h3d, 8'h42, 8'h46, 8'h4d, 8'h50, 8'h55, 8'h6b, 8'h77,
    8'h09, 8'h22, 8'h27, 8'h2a, 8'h2f, 8'h36, 8'h39, 8'h3a, 8'h47, 8'h48, 8'h57,
    8'h5b, 8'h5f, 8'h76, 8'h78, 8'h79,
    8'h2b, 8'h3e, 8'h4b, 8'h56, 8'h58, 8'h59, 8'h5d,
    8'h21, 8'h24, 8'h26, 8'h71, 8'h7a,
    8'h00, 8'h3c, 8'h3f, 8'h4a, 8'h51, 8'h5a, 8'h5c, 8'h6a, 8'h7b, 8'h7c,
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h0b, 8'h0c, 8'h0e, 8'h0f,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1b, 8'h1c,
    8'h1d, 8'h1e, 8'h1f, 8'h23, 8'h25, 8'h3b, 8'h40, 8'h5e, 8'h60, 8'h7d, 8'h7e, 8'h7f,
    8'hb0, 8'hb1, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hbb,
    8'hbc, 8'hbd, 8'hbe, 8'hbf, 8'hc0, 8'hc1, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
    8'hc8, 8'hc9, 8'hca, 8'hcb, 8'hcc, 8'hcd, 8'hce, 8'hcf, 8'hd0, 8'hd1, 8'hd2, 8'hd3,
    8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde, 8'hdf,
    8'he1, 8'he5, 8'he9, 8'hee, 8'hf2, 8'hf3, 8'hf4,
    8'h1a, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
    8'h97, 8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'h9f, 8'ha0, 8'ha1, 8'ha2,
    8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hab, 8'hac, 8'had, 8'hae,
    8'haf, 8'he0, 8'he2, 8'he3, 8'he4, 8'he6, 8'he7, 8'he8, 8'hea, 8'heb, 8'hec, 8'hed,
    8'hef, 8'hf0, 8'hf1, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd,
    8'hfe, 8'hff
  };

  // ASCII literal groups: first rank, code width, code of the first rank
  localparam int ASC_FIRST [10] = '{182, 91, 81, 76, 69, 53, 32, 12, 1, 0};
  localparam int ASC_WIDTH [10] = '{13, 12, 11, 10, 9, 8, 7, 6, 5, 4};
  localparam int ASC_CODE  [10] = '{'h49, 'h7F, 'h49, 'h29, 'h1b, 'h1d, 'h23, 'h25, 'h1d,
                                    'h0F};

  // offset high part groups
  localparam int HI_FIRST [6] = '{'h30, 'h16, 'h07, 'h03, 'h01, 'h00};
  localparam int HI_WIDTH [6] = '{8, 7, 6, 5, 4, 2};
  localparam int HI_CODE  [6] = '{'h0F, 'h21, 'h1F, 'h13, 'h0B, 'h03};

  // length groups
  localparam int LEN_FIRST   [16] = '{264, 136, 72, 40, 24, 16, 12, 10, 9, 8, 7, 6, 5, 4,
                                      3, 2};
  localparam int LEN_WIDTH   [16] = '{7, 7, 6, 6, 6, 5, 5, 5, 5, 4, 4, 4, 3, 3, 2, 3};
  localparam int LEN_CODEVAL [16] = '{0, 1, 1, 2, 3, 2, 3, 4, 5, 3, 4, 5, 3, 4, 3, 5};
  localparam int LEN_EXTRA   [16] = '{8, 7, 6, 5, 4, 3, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0};

  localparam int LONGEST_LEN = 518;
  localparam int HOLD_CYCLES = 300;

  class stream_scoreboard;
    bit          ascii_mode;
    logic [2:0]  dict_reg;
    logic [6:0]  carry_bits;
    int          carry_cnt;
    logic [63:0] acc;
    int          acc_n;
    logic [8:0]  stream_q[$];  // {last, byte}
    int          mismatches;
    int          bytes_seen;
    int          tokens_seen;

    function new();
      ascii_mode  = 1'b0;
      dict_reg    = 3'd6;
      carry_bits  = '0;
      carry_cnt   = 0;
      mismatches  = 0;
      bytes_seen  = 0;
      tokens_seen = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [2:0] data);
      if (idx == CFG_LIT_MODE) begin
        ascii_mode = data[0];
      end else begin
        dict_reg = data;
      end
    endfunction

    function int window_bits();
      if (dict_reg < 3'd4) return 4;
      if (dict_reg > 3'd6) return 6;
      return int'(dict_reg);
    endfunction

    function void emit_lsb(int n, logic [31:0] v);
      for (int i = 0; i < n; i++) begin
        acc[acc_n] = v[i];
        acc_n++;
      end
    endfunction

    function void emit_msb(int n, logic [31:0] v);
      for (int i = n - 1; i >= 0; i--) begin
        acc[acc_n] = v[i];
        acc_n++;
      end
    endfunction

    function void encode_literal(logic [7:0] lit);
      int rank;
      int g;
      rank = 255;
      g = 0;
      emit_lsb(1, 0);
      if (!ascii_mode) begin
        emit_lsb(8, lit);
        return;
      end
      // a value listed twice takes its highest rank
      for (int i = 255; i >= 0; i--) begin
        if (RANK_VALUE[i] == lit) begin
          rank = i;
          break;
        end
      end
      while (g < 9 && rank < ASC_FIRST[g]) g++;
      emit_msb(ASC_WIDTH[g], ASC_CODE[g] - (rank - ASC_FIRST[g]));
    endfunction

    function void encode_match(logic [9:0] len_in, logic [11:0] off);
      int len;
      int low;
      int hi;
      int g;
      len = int'(len_in);
      if (len < 2) len = 2;
      if (len > LONGEST_LEN) len = LONGEST_LEN;
      low = (len == 2) ? 2 : window_bits();
      g = 0;
      while (g < 15 && len < LEN_FIRST[g]) g++;
      emit_lsb(1, 1);
      emit_msb(LEN_WIDTH[g], LEN_CODEVAL[g]);
      emit_lsb(LEN_EXTRA[g], len - LEN_FIRST[g]);
      hi = (int'(off) >> low) & 'h3F;
      g = 0;
      while (g < 5 && hi < HI_FIRST[g]) g++;
      emit_msb(HI_WIDTH[g], HI_CODE[g] - (hi - HI_FIRST[g]));
      emit_lsb(low, off);
    endfunction

    function void note_token(logic [1:0] op, logic [7:0] lit, logic [9:0] len,
                             logic [11:0] off);
      int nbytes;
      tokens_seen++;
      if (op == OP_START) begin
        carry_bits = '0;
        carry_cnt  = 0;
        stream_q.push_back({1'b0, 7'd0, ascii_mode});
        stream_q.push_back({1'b1, 8'(window_bits())});
        return;
      end
      acc   = 64'(carry_bits);
      acc_n = carry_cnt;
      case (op)
        OP_LIT:   encode_literal(lit);
        OP_MATCH: encode_match(len, off);
        default: begin
          // end marker: length code for 519 with all-ones extra bits
          emit_lsb(1, 1);
          emit_msb(7, 0);
          emit_lsb(8, 'hFF);
          acc_n = (acc_n + 7) / 8 * 8;
        end
      endcase
      nbytes = acc_n / 8;
      for (int k = 0; k < nbytes; k++) begin
        stream_q.push_back({k == nbytes - 1, acc[7:0]});
        acc = acc >> 8;
      end
      carry_cnt  = acc_n % 8;
      carry_bits = acc[6:0];
    endfunction

    function void check_byte(logic [7:0] data, logic lst);
      logic [8:0] exp_item;
      bytes_seen++;
      if (stream_q.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b", $time, data, lst);
        mismatches++;
        return;
      end
      exp_item = stream_q.pop_front();
      if (exp_item[7:0] !== data) begin
        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                 $time, exp_item[7:0], data);
        mismatches++;
      end
      if (exp_item[8] !== lst) begin
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, exp_item[8], lst);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [2:0] cfg_data_i;

  dtbe_tok_if  tok_ch ();
  dtbe_byte_if byte_ch ();

  dcl_token_bitstream_encoder_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tok        (tok_ch),
    .bytes      (byte_ch)
  );

  stream_scoreboard sb = new();
  bit tx_no_gap;
  bit rx_no_stall;
  bit hold_req;
  int settings_used;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAIL dcl_token_bitstream_encoder_core");
    $finish;
  end

  // sender; called at a rising edge, returns at the edge of the transaction
  task automatic send_token(logic [1:0] op, logic [7:0] lit, logic [9:0] len,
                            logic [11:0] off);
    int gap;
    bit rdy;
    gap = tx_no_gap ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      tok_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tok_ch.valid        <= 1'b1;
    tok_ch.op           <= op;
    tok_ch.literal      <= lit;
    tok_ch.match_length <= len;
    tok_ch.offset       <= off;
    do begin
      @(negedge clk_i);
      rdy = tok_ch.ready;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_token(op, lit, len, off);
  endtask

  // idle the token side, let the stream drain, then write both registers
  task automatic set_config(logic [2:0] mode_data, logic [2:0] dict_data);
    tok_ch.valid <= 1'b0;
    while (sb.stream_q.size() != 0) @(posedge clk_i);
    // tokens without output may still sit in the pipeline
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LIT_MODE;
    cfg_data_i <= mode_data;
    @(posedge clk_i);
    sb.write_reg(CFG_LIT_MODE, mode_data);
    cfg_idx_i  <= CFG_DICT_BITS;
    cfg_data_i <= dict_data;
    @(posedge clk_i);
    sb.write_reg(CFG_DICT_BITS, dict_data);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random_token(bit noise_ok);
    logic [1:0]  op;
    logic [7:0]  lit;
    logic [9:0]  len;
    logic [11:0] off;
    int r;
    r = $urandom_range(0, 99);
    op = (r < 45) ? OP_LIT : OP_MATCH;
    if (noise_ok && r >= 92) op = 2'($urandom_range(0, 3));
    if (sb.ascii_mode && $urandom_range(0, 1)) lit = 8'($urandom_range('h20, 'h7E));
    else lit = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 55) len = 10'($urandom_range(2, 12));
    else if (r < 85) len = 10'($urandom_range(13, LONGEST_LEN));
    else len = 10'($urandom_range(0, 1023));
    if ($urandom_range(0, 1)) off = 12'($urandom_range(0, 4095));
    else off = 12'($urandom_range(0, 255));
    send_token(op, lit, len, off);
  endtask

  // receiver
  initial begin
    logic       v;
    logic [7:0] rx_data;
    logic       rx_last;
    int         stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        // long hold-off: the internal queue fills and the token side stalls
        hold_req = 1'b0;
        byte_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!rx_no_stall) begin
        stall = $urandom_range(0, 19);
        if (stall > 0) begin
          byte_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      byte_ch.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        v       = byte_ch.valid;
        rx_data = byte_ch.out_byte;
        rx_last = byte_ch.last;
        @(posedge clk_i);
      end while (!v);
      sb.check_byte(rx_data, rx_last);
    end
  end

  initial begin
    int random_sent;
    int body;
    int phase;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_LIT_MODE;
    cfg_data_i           = '0;
    tok_ch.valid         = 1'b0;
    tok_ch.op            = OP_START;
    tok_ch.literal       = '0;
    tok_ch.match_length  = '0;
    tok_ch.offset        = '0;
    byte_ch.ready        = 1'b0;
    tx_no_gap            = 1'b0;
    rx_no_stall          = 1'b0;
    hold_req             = 1'b0;
    settings_used        = 1;
    random_sent          = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: raw literals, 6 window bits
    send_token(OP_START, 8'h00, 10'd0, 12'd0);
    send_token(OP_LIT, 8'h00, 10'd0, 12'd0);
    send_token(OP_LIT, 8'hFF, 10'd0, 12'd0);
    send_token(OP_MATCH, 8'h00, 10'd2, 12'd0);
    send_token(OP_MATCH, 8'h00, 10'd2, 12'd4095);  // short match, offset wraps
    send_token(OP_MATCH, 8'h00, 10'd518, 12'd4095);
    send_token(OP_MATCH, 8'h00, 10'd1023, 12'd0);  // clamped to the longest length
    send_token(OP_MATCH, 8'h00, 10'd0, 12'd17);    // clamped to length two
    send_token(OP_MATCH, 8'h00, 10'd264, 12'd63);
    send_token(OP_FINISH, 8'h00, 10'd0, 12'd0);

    // ASCII literals, window bits below range
    set_config(3'b001, 3'd0);
    send_token(OP_START, 8'h00, 10'd0, 12'd0);
    send_token(OP_LIT, 8'h20, 10'd0, 12'd0);  // 5 bits, completes no byte
    send_token(OP_LIT, 8'hFF, 10'd0, 12'd0);
    send_token(OP_LIT, 8'h1A, 10'd0, 12'd0);
    send_token(OP_LIT, 8'h00, 10'd0, 12'd0);
    send_token(OP_LIT, 8'h7F, 10'd0, 12'd0);
    send_token(OP_MATCH, 8'h00, 10'd3, 12'd4095);
    send_token(OP_START, 8'h00, 10'd0, 12'd0);  // drops the pending bits
    send_token(OP_FINISH, 8'h00, 10'd0, 12'd0);
    send_token(OP_FINISH, 8'h00, 10'd0, 12'd0);

    // raw literals via an even write value, window bits above range
    set_config(3'b110, 3'd7);
    send_token(OP_START, 8'h00, 10'd0, 12'd0);
    send_token(OP_MATCH, 8'h00, 10'd136, 12'd4095);
    send_token(OP_LIT, 8'hA5, 10'd0, 12'd0);
    send_token(OP_FINISH, 8'h00, 10'd0, 12'd0);

    phase = 0;
    while (random_sent < 130) begin
      case (phase)
        0:       set_config(3'($urandom_range(0, 7)), 3'd4);
        1:       set_config(3'($urandom_range(0, 7)), 3'd6);
        default: set_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      endcase
      tx_no_gap   = (phase % 4 == 1) || (phase == 3);
      rx_no_stall = (phase % 4 == 2);
      if (phase == 3) hold_req = 1'b1;
      send_token(OP_START, 8'h00, 10'd0, 12'd0);
      body = $urandom_range(15, 35);
      for (int i = 0; i < body; i++) begin
        send_random_token(1'b1);
      end
      send_token(OP_FINISH, 8'h00, 10'd0, 12'd0);
      random_sent += body + 2;
      phase++;
    end

    tok_ch.valid <= 1'b0;
    while (sb.stream_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d tokens under %0d register settings, %0d stream bytes checked",
             sb.tokens_seen, settings_used, sb.bytes_seen);
    $display("Mismatches found: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS dcl_token_bitstream_encoder_core");
    end else begin
      $display("FAIL dcl_token_bitstream_encoder_core");
    end
    $finish;
  end

endmodule

@@ dcl_token_bitstream_encoder_core.f @@
hw/rtl/dtbe_pkg.sv
hw/rtl/dtbe_if.sv
hw/rtl/dtbe_front.sv
hw/rtl/dtbe_queue.sv
hw/rtl/dtbe_back.sv
hw/rtl/dcl_token_bitstream_encoder_core.sv
bench/dcl_token_bitstream_encoder_core_test.sv
